@@ sv/bbt_pkg.sv @@
// bbt_pkg: shared widths, command and register codes, and handshake structs
// for the song position counter; no dependencies
package bbt_pkg;

  localparam int POSITION_WIDTH = 32;
  localparam int TPB_WIDTH      = 16;
  localparam int BPB_WIDTH      = 8;
  localparam int CMD_WIDTH      = 4;
  localparam int BAR_SET_WIDTH  = 16;
  localparam int CFG_IDX_WIDTH  = 1;
  localparam int CFG_DATA_WIDTH = 16;

  localparam logic [TPB_WIDTH-1:0] TPB_RESET = TPB_WIDTH'(96);
  localparam logic [BPB_WIDTH-1:0] BPB_RESET = BPB_WIDTH'(4);

  localparam logic [CFG_IDX_WIDTH-1:0] REG_TICKS_PER_BEAT = 1'b0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_BEATS_PER_BAR  = 1'b1;

  localparam logic [CMD_WIDTH-1:0] CMD_TICK_UP  = 4'd0;
  localparam logic [CMD_WIDTH-1:0] CMD_TICK_DN  = 4'd1;
  localparam logic [CMD_WIDTH-1:0] CMD_BEAT_UP  = 4'd2;
  localparam logic [CMD_WIDTH-1:0] CMD_BEAT_DN  = 4'd3;
  localparam logic [CMD_WIDTH-1:0] CMD_BAR_UP   = 4'd4;
  localparam logic [CMD_WIDTH-1:0] CMD_BAR_DN   = 4'd5;
  localparam logic [CMD_WIDTH-1:0] CMD_SET      = 4'd6;
  localparam logic [CMD_WIDTH-1:0] CMD_CLEAR    = 4'd7;
  localparam logic [CMD_WIDTH-1:0] CMD_QUANTIZE = 4'd8;

  // serial multiply: one multiplier bit per cycle
  localparam int MUL_STEPS     = TPB_WIDTH;
  localparam int MUL_CNT_WIDTH = $clog2(MUL_STEPS);

  // serial divide: quotient digit of DIV_DIGIT bits per cycle
  localparam int DIV_DIGIT     = 2;
  localparam int DIV_STEPS     = POSITION_WIDTH / DIV_DIGIT;
  localparam int DIV_CNT_WIDTH = $clog2(DIV_STEPS);

  typedef logic [POSITION_WIDTH-1:0] pos_t;
  typedef logic [TPB_WIDTH-1:0]      tpb_t;
  typedef logic [BPB_WIDTH-1:0]      bpb_t;

  typedef struct packed {
    logic start;
    pos_t acc_init;
    pos_t mcand;
    tpb_t mplier;
  } mul_req_t;

  typedef struct packed {
    logic done;
    pos_t product;
  } mul_rsp_t;

  typedef struct packed {
    logic start;
    pos_t dividend;
    tpb_t divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    pos_t quotient;
    tpb_t remainder;
  } div_rsp_t;

endpackage

@@ sv/bbt_cmd_if.sv @@
// bbt_cmd_if: valid/ready channel carrying one command word
// depends on bbt_pkg for field widths
interface bbt_cmd_if;
  logic                             valid;
  logic                             ready;
  logic [bbt_pkg::CMD_WIDTH-1:0]     cmd;
  logic [bbt_pkg::BAR_SET_WIDTH-1:0] set_bar;
  logic [bbt_pkg::BPB_WIDTH-1:0]     set_beat;
  logic [bbt_pkg::TPB_WIDTH-1:0]     set_tick;

  modport source (output valid, cmd, set_bar, set_beat, set_tick, input ready);
  modport sink (input valid, cmd, set_bar, set_beat, set_tick, output ready);
endinterface

@@ sv/bbt_res_if.sv @@
// bbt_res_if: valid/ready channel carrying one position result word
// depends on bbt_pkg for field widths
interface bbt_res_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [bbt_pkg::POSITION_WIDTH-1:0] position_ticks;
  logic signed [bbt_pkg::POSITION_WIDTH-1:0] bar_number;
  logic [bbt_pkg::BPB_WIDTH-1:0]             beat_in_bar;
  logic [bbt_pkg::TPB_WIDTH-1:0]             tick_in_beat;

  modport source (output valid, position_ticks, bar_number, beat_in_bar, tick_in_beat,
                  input ready);
  modport sink (input valid, position_ticks, bar_number, beat_in_bar, tick_in_beat,
                output ready);
endinterface

@@ sv/bar_beat_tick_position_counter_core.sv @@
// bar_beat_tick_position_counter_core: command sequencer, position, config and output
// registers; uses bbt_pkg, bbt_cmd_if, bbt_res_if, bbt_mul and bbt_div
// accept to result: tick, beat, clear and unknown codes run two divider passes (ticks
// per beat, then beats per bar); bar steps add a multiply, set two, quantize a divide and a multiply
// one command in flight, next taken only once its result word has loaded
// reset (synchronous): position 0, ticks_per_beat 96, beats_per_bar 4, no result word
module bar_beat_tick_position_counter_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [bbt_pkg::CFG_IDX_WIDTH-1:0]    cfg_index,
  input  logic [bbt_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
  bbt_cmd_if.sink                              command,
  bbt_res_if.source                            result
);

  localparam int W  = bbt_pkg::POSITION_WIDTH;
  localparam int SW = 4;

  localparam logic [SW-1:0] S_IDLE = 4'd0;
  localparam logic [SW-1:0] S_EXEC = 4'd1;
  localparam logic [SW-1:0] S_MUL1 = 4'd2;
  localparam logic [SW-1:0] S_MUL2 = 4'd3;
  localparam logic [SW-1:0] S_QDIV = 4'd4;
  localparam logic [SW-1:0] S_QMUL = 4'd5;
  localparam logic [SW-1:0] S_BRK  = 4'd6;
  localparam logic [SW-1:0] S_DIV1 = 4'd7;
  localparam logic [SW-1:0] S_FIX1 = 4'd8;
  localparam logic [SW-1:0] S_DIV2 = 4'd9;
  localparam logic [SW-1:0] S_OUT  = 4'd10;

  bbt_pkg::tpb_t tpb;
  bbt_pkg::bpb_t bpb;
  bbt_pkg::tpb_t tpb_eff;
  bbt_pkg::bpb_t bpb_eff;

  logic [SW-1:0] state;
  logic [SW-1:0] state_next;

  logic [bbt_pkg::CMD_WIDTH-1:0]     cmd_q;
  logic [bbt_pkg::BAR_SET_WIDTH-1:0] set_bar_q;
  bbt_pkg::bpb_t                     set_beat_q;
  bbt_pkg::tpb_t                     set_tick_q;

  bbt_pkg::pos_t position;
  bbt_pkg::pos_t position_next;
  logic          neg;
  logic          neg_next;
  bbt_pkg::pos_t quo_fl;
  bbt_pkg::pos_t quo_fl_next;
  bbt_pkg::tpb_t tick_q;
  bbt_pkg::tpb_t tick_next;
  bbt_pkg::pos_t bar_q;
  bbt_pkg::pos_t bar_next;
  bbt_pkg::bpb_t beat_q;
  bbt_pkg::bpb_t beat_next;

  bbt_pkg::pos_t pos_abs;
  bbt_pkg::pos_t quo_abs;

  bbt_pkg::mul_req_t mul_req;
  bbt_pkg::mul_rsp_t mul_rsp;
  bbt_pkg::div_req_t div_req;
  bbt_pkg::div_rsp_t div_rsp;

  logic          load_out;
  logic          res_valid;
  bbt_pkg::pos_t res_pos;
  bbt_pkg::pos_t res_bar;
  bbt_pkg::bpb_t res_beat;
  bbt_pkg::tpb_t res_tick;

  bbt_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  bbt_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tpb <= bbt_pkg::TPB_RESET;
      bpb <= bbt_pkg::BPB_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bbt_pkg::REG_TICKS_PER_BEAT: tpb <= cfg_data;
        bbt_pkg::REG_BEATS_PER_BAR:  bpb <= cfg_data[bbt_pkg::BPB_WIDTH-1:0];
      endcase
    end
  end

  // zero length acts as one
  assign tpb_eff = (tpb == '0) ? bbt_pkg::TPB_WIDTH'(1) : tpb;
  assign bpb_eff = (bpb == '0) ? bbt_pkg::BPB_WIDTH'(1) : bpb;

  assign pos_abs = position[W-1] ? (~position + 1'b1) : position;
  assign quo_abs = quo_fl[W-1] ? (~quo_fl + 1'b1) : quo_fl;

  assign command.ready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    position_next = position;
    neg_next      = neg;
    quo_fl_next   = quo_fl;
    tick_next     = tick_q;
    bar_next      = bar_q;
    beat_next     = beat_q;
    mul_req       = '0;
    div_req       = '0;
    load_out      = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (command.valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_BRK;
        unique case (cmd_q)
          bbt_pkg::CMD_TICK_UP: position_next = position + 1'b1;
          bbt_pkg::CMD_TICK_DN: position_next = position - 1'b1;
          bbt_pkg::CMD_BEAT_UP: position_next = position + W'(tpb_eff);
          bbt_pkg::CMD_BEAT_DN: position_next = position - W'(tpb_eff);
          bbt_pkg::CMD_BAR_UP, bbt_pkg::CMD_BAR_DN: begin
            mul_req.start    = 1'b1;
            mul_req.acc_init = '0;
            mul_req.mcand    = W'(bpb_eff);
            mul_req.mplier   = tpb_eff;
            state_next       = S_MUL1;
          end
          bbt_pkg::CMD_SET: begin
            // beats from the start: set_bar * bpb + set_beat
            mul_req.start    = 1'b1;
            mul_req.acc_init = W'(set_beat_q);
            mul_req.mcand    = W'(set_bar_q);
            mul_req.mplier   = bbt_pkg::TPB_WIDTH'(bpb_eff);
            state_next       = S_MUL1;
          end
          bbt_pkg::CMD_CLEAR: position_next = '0;
          bbt_pkg::CMD_QUANTIZE: begin
            div_req.start    = 1'b1;
            div_req.dividend = pos_abs;
            div_req.divisor  = tpb_eff;
            neg_next         = position[W-1];
            state_next       = S_QDIV;
          end
          default: ;
        endcase
      end
      S_MUL1: begin
        if (mul_rsp.done) begin
          state_next = S_BRK;
          unique case (cmd_q)
            bbt_pkg::CMD_BAR_UP: position_next = position + mul_rsp.product;
            bbt_pkg::CMD_BAR_DN: position_next = position - mul_rsp.product;
            default: begin
              mul_req.start    = 1'b1;
              mul_req.acc_init = W'(set_tick_q);
              mul_req.mcand    = mul_rsp.product;
              mul_req.mplier   = tpb_eff;
              state_next       = S_MUL2;
            end
          endcase
        end
      end
      S_MUL2: begin
        if (mul_rsp.done) begin
          position_next = mul_rsp.product;
          state_next    = S_BRK;
        end
      end
      S_QDIV: begin
        if (div_rsp.done) begin
          mul_req.start    = 1'b1;
          mul_req.acc_init = '0;
          mul_req.mcand    = div_rsp.quotient;
          mul_req.mplier   = tpb_eff;
          state_next       = S_QMUL;
        end
      end
      S_QMUL: begin
        if (mul_rsp.done) begin
          position_next = neg ? (~mul_rsp.product + 1'b1) : mul_rsp.product;
          state_next    = S_BRK;
        end
      end
      S_BRK: begin
        div_req.start    = 1'b1;
        div_req.dividend = pos_abs;
        div_req.divisor  = tpb_eff;
        neg_next         = position[W-1];
        state_next       = S_DIV1;
      end
      S_DIV1: begin
        if (div_rsp.done) begin
          // floor correction of the beat index and tick
          if (!neg) begin
            quo_fl_next = div_rsp.quotient;
            tick_next   = div_rsp.remainder;
          end else if (div_rsp.remainder != '0) begin
            quo_fl_next = ~div_rsp.quotient;
            tick_next   = tpb_eff - div_rsp.remainder;
          end else begin
            quo_fl_next = ~div_rsp.quotient + 1'b1;
            tick_next   = '0;
          end
          state_next = S_FIX1;
        end
      end
      S_FIX1: begin
        div_req.start    = 1'b1;
        div_req.dividend = quo_abs;
        div_req.divisor  = bbt_pkg::TPB_WIDTH'(bpb_eff);
        neg_next         = quo_fl[W-1];
        state_next       = S_DIV2;
      end
      S_DIV2: begin
        if (div_rsp.done) begin
          if (!neg) begin
            bar_next  = div_rsp.quotient;
            beat_next = div_rsp.remainder[bbt_pkg::BPB_WIDTH-1:0];
          end else if (div_rsp.remainder != '0) begin
            bar_next  = ~div_rsp.quotient;
            beat_next = bpb_eff - div_rsp.remainder[bbt_pkg::BPB_WIDTH-1:0];
          end else begin
            bar_next  = ~div_rsp.quotient + 1'b1;
            beat_next = '0;
          end
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!res_valid || result.ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      position <= '0;
      neg      <= 1'b0;
    end else begin
      state    <= state_next;
      position <= position_next;
      neg      <= neg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (command.valid && command.ready) begin
      cmd_q      <= command.cmd;
      set_bar_q  <= command.set_bar;
      set_beat_q <= command.set_beat;
      set_tick_q <= command.set_tick;
    end
    quo_fl <= quo_fl_next;
    tick_q <= tick_next;
    bar_q  <= bar_next;
    beat_q <= beat_next;
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_out) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      res_pos  <= position;
      res_bar  <= bar_q;
      res_beat <= beat_q;
      res_tick <= tick_q;
    end
  end

  assign result.valid          = res_valid;
  assign result.position_ticks = $signed(res_pos);
  assign result.bar_number     = $signed(res_bar);
  assign result.beat_in_bar    = res_beat;
  assign result.tick_in_beat   = res_tick;

`ifndef SYNTHESIS
  a_valid_from_out : assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state) == S_OUT)
    else $error("result word raised outside the output state");

  a_idle_holds_pos : assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |=> $stable(position))
    else $error("position changed while idle");

  a_div_done_state : assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_QDIV || state == S_DIV1 || state == S_DIV2))
    else $error("divider finished with no waiting state");

  a_breakdown_range : assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.beat_in_bar < bpb_eff && result.tick_in_beat < tpb_eff))
    else $error("beat or tick outside its range");
`endif

endmodule

@@ sv/bbt_mul.sv @@
// bbt_mul: shift-add multiplier, one multiplier bit per cycle, with accumulate
// start value; depends on bbt_pkg
module bbt_mul (
  input  logic              clk,
  input  logic              rst,
  input  bbt_pkg::mul_req_t req,
  output bbt_pkg::mul_rsp_t rsp
);

  bbt_pkg::pos_t                     acc;
  bbt_pkg::pos_t                     mcand;
  bbt_pkg::tpb_t                     mplier;
  logic [bbt_pkg::MUL_CNT_WIDTH-1:0] count;
  logic                              busy;
  logic                              done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == bbt_pkg::MUL_CNT_WIDTH'(bbt_pkg::MUL_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc    <= req.acc_init;
      mcand  <= req.mcand;
      mplier <= req.mplier;
    end else if (busy) begin
      if (mplier[0]) begin
        acc <= acc + mcand;
      end
      mcand  <= {mcand[bbt_pkg::POSITION_WIDTH-2:0], 1'b0};
      mplier <= {1'b0, mplier[bbt_pkg::TPB_WIDTH-1:1]};
    end
  end

  assign rsp.done    = done;
  assign rsp.product = acc;

endmodule

@@ sv/bbt_div.sv @@
// bbt_div: unsigned restoring divider, a two-bit quotient digit per cycle
// depends on bbt_pkg
module bbt_div (
  input  logic              clk,
  input  logic              rst,
  input  bbt_pkg::div_req_t req,
  output bbt_pkg::div_rsp_t rsp
);

  localparam int W = bbt_pkg::POSITION_WIDTH;
  localparam int D = bbt_pkg::TPB_WIDTH;

  bbt_pkg::pos_t                     quo;
  bbt_pkg::tpb_t                     rem;
  bbt_pkg::tpb_t                     divisor;
  logic [bbt_pkg::DIV_CNT_WIDTH-1:0] count;
  logic                              busy;
  logic                              done;

  bbt_pkg::pos_t quo_step;
  bbt_pkg::tpb_t rem_step;
  logic [D:0]    trial;

  always_comb begin
    quo_step = quo;
    rem_step = rem;
    trial    = '0;
    for (int i = 0; i < bbt_pkg::DIV_DIGIT; i++) begin
      trial    = {rem_step, quo_step[W-1]};
      quo_step = {quo_step[W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        trial       = trial - {1'b0, divisor};
        quo_step[0] = 1'b1;
      end
      rem_step = trial[D-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == bbt_pkg::DIV_CNT_WIDTH'(bbt_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo     <= req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      quo <= quo_step;
      rem <= rem_step;
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

@@ tb/tb_bar_beat_tick_position_counter_core.sv @@
`timescale 1ns / 100ps
// tb_bar_beat_tick_position_counter_core: self-checking bench for the song position counter,
// random command words against an in-bench position predictor under random stalls
// depends on bbt_pkg, bbt_cmd_if, bbt_res_if and bar_beat_tick_position_counter_core
module tb_bar_beat_tick_position_counter_core;

  localparam int STALL_LIMIT      = 3000;
  localparam int HOLD_CYCLES      = 300;
  localparam int HOLD_AFTER       = 60;
  localparam int RANDOM_PER_PHASE = 112;
  localparam int SETTLE_CYCLES    = 100;
  localparam int NUM_PHASES       = 8;

  typedef struct {
    logic [bbt_pkg::CMD_WIDTH-1:0]     cmd;
    logic [bbt_pkg::BAR_SET_WIDTH-1:0] set_bar;
    bbt_pkg::bpb_t                     set_beat;
    bbt_pkg::tpb_t                     set_tick;
  } cmd_word_t;

  typedef struct packed {
    bbt_pkg::pos_t position_ticks;
    bbt_pkg::pos_t bar_number;
    bbt_pkg::bpb_t beat_in_bar;
    bbt_pkg::tpb_t tick_in_beat;
  } position_word_t;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               cfg_write;
  logic [bbt_pkg::CFG_IDX_WIDTH-1:0]  cfg_index;
  logic [bbt_pkg::CFG_DATA_WIDTH-1:0] cfg_data;

  bbt_cmd_if command_ch();
  bbt_res_if result_ch();

  bar_beat_tick_position_counter_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .command   (command_ch),
    .result    (result_ch)
  );

  always #2 clk = ~clk;

  // predictor state
  bbt_pkg::pos_t song_pos;
  bbt_pkg::tpb_t ticks_per_beat_q;
  bbt_pkg::bpb_t beats_per_bar_q;

  cmd_word_t      pending_cmds[$];
  position_word_t expected_positions[$];

  int  cmds_issued   = 0;
  int  cmds_accepted = 0;
  int  mismatches    = 0;
  int  quiet_cycles  = 0;
  bit  idling_on     = 1'b1;
  int  send_gap      = 0;
  int  stall_left    = 0;
  int  hold_left     = 0;
  bit  held_once     = 1'b0;

  function automatic position_word_t apply_command(cmd_word_t w);
    longint beat_len, bar_beats, bar_len, s, tick, beat, bar, f_bar, f_beat, f_tick;
    position_word_t r;
    beat_len  = (ticks_per_beat_q == '0) ? 1 : ticks_per_beat_q;
    bar_beats = (beats_per_bar_q == '0) ? 1 : beats_per_bar_q;
    bar_len   = beat_len * bar_beats;
    f_bar     = w.set_bar;
    f_beat    = w.set_beat;
    f_tick    = w.set_tick;
    case (w.cmd)
      bbt_pkg::CMD_TICK_UP:  song_pos = song_pos + bbt_pkg::pos_t'(1);
      bbt_pkg::CMD_TICK_DN:  song_pos = song_pos - bbt_pkg::pos_t'(1);
      bbt_pkg::CMD_BEAT_UP:  song_pos = song_pos + bbt_pkg::pos_t'(beat_len);
      bbt_pkg::CMD_BEAT_DN:  song_pos = song_pos - bbt_pkg::pos_t'(beat_len);
      bbt_pkg::CMD_BAR_UP:   song_pos = song_pos + bbt_pkg::pos_t'(bar_len);
      bbt_pkg::CMD_BAR_DN:   song_pos = song_pos - bbt_pkg::pos_t'(bar_len);
      bbt_pkg::CMD_SET:
        song_pos = bbt_pkg::pos_t'(f_tick + beat_len * f_beat + bar_len * f_bar);
      bbt_pkg::CMD_CLEAR:    song_pos = '0;
      bbt_pkg::CMD_QUANTIZE: begin
        s = $signed(song_pos);
        song_pos = bbt_pkg::pos_t'((s / beat_len) * beat_len);
      end
      default: ;
    endcase
    s    = $signed(song_pos);
    tick = s % beat_len;
    beat = (s / beat_len) % bar_beats;
    bar  = s / bar_len;
    if (tick < 0) begin
      tick = tick + beat_len;
      beat = beat - 1;
    end
    if (beat < 0) begin
      beat = beat + bar_beats;
      bar  = bar - 1;
    end
    r.position_ticks = song_pos;
    r.bar_number     = bbt_pkg::pos_t'(bar);
    r.beat_in_bar    = bbt_pkg::bpb_t'(beat);
    r.tick_in_beat   = bbt_pkg::tpb_t'(tick);
    return r;
  endfunction

  // sender: holds a word until taken, idles in bursts
  always @(negedge clk) begin : cmd_driver
    cmd_word_t w;
    if (rst) begin
      command_ch.valid <= 1'b0;
    end else if (!(command_ch.valid && cmds_accepted != cmds_issued)) begin
      if (send_gap > 0) begin
        send_gap = send_gap - 1;
        command_ch.valid <= 1'b0;
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
        send_gap = $urandom_range(0, 12);
        command_ch.valid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        w = pending_cmds.pop_front();
        command_ch.cmd      <= w.cmd;
        command_ch.set_bar  <= w.set_bar;
        command_ch.set_beat <= w.set_beat;
        command_ch.set_tick <= w.set_tick;
        command_ch.valid    <= 1'b1;
        cmds_issued = cmds_issued + 1;
      end else begin
        command_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off to back the block up
  always @(negedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      result_ch.ready <= 1'b0;
    end else if (!held_once && cmds_accepted >= HOLD_AFTER) begin
      held_once = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      result_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      result_ch.ready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 12);
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : monitor
    position_word_t want, got;
    cmd_word_t      w;
    bit             progress;
    if (!rst) begin
      progress = cfg_write;
      if (result_ch.valid && result_ch.ready) begin
        progress = 1'b1;
        got.position_ticks = result_ch.position_ticks;
        got.bar_number     = result_ch.bar_number;
        got.beat_in_bar    = result_ch.beat_in_bar;
        got.tick_in_beat   = result_ch.tick_in_beat;
        if (expected_positions.size() == 0) begin
          $display("%0t: unexpected result word pos %0d bar %0d beat %0d tick %0d", $time,
                   $signed(got.position_ticks), $signed(got.bar_number), got.beat_in_bar,
                   got.tick_in_beat);
          mismatches = mismatches + 1;
        end else begin
          want = expected_positions.pop_front();
          if (got != want) begin
            $display("%0t: result mismatch, expected pos %0d bar %0d beat %0d tick %0d",
                     $time, $signed(want.position_ticks), $signed(want.bar_number),
                     want.beat_in_bar, want.tick_in_beat);
            $display("%0t:                  actual pos %0d bar %0d beat %0d tick %0d",
                     $time, $signed(got.position_ticks), $signed(got.bar_number),
                     got.beat_in_bar, got.tick_in_beat);
            mismatches = mismatches + 1;
          end
        end
      end
      if (command_ch.valid && command_ch.ready) begin
        progress   = 1'b1;
        w.cmd      = command_ch.cmd;
        w.set_bar  = command_ch.set_bar;
        w.set_beat = command_ch.set_beat;
        w.set_tick = command_ch.set_tick;
        expected_positions.push_back(apply_command(w));
        cmds_accepted = cmds_accepted + 1;
      end
      quiet_cycles = progress ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic push_cmd(logic [bbt_pkg::CMD_WIDTH-1:0] c, int bar_v, int beat_v,
                          int tick_v);
    cmd_word_t w;
    w.cmd      = c;
    w.set_bar  = bbt_pkg::BAR_SET_WIDTH'(bar_v);
    w.set_beat = bbt_pkg::BPB_WIDTH'(beat_v);
    w.set_tick = bbt_pkg::TPB_WIDTH'(tick_v);
    pending_cmds.push_back(w);
  endtask

  task automatic push_random(int count);
    cmd_word_t w;
    int        roll;
    repeat (count) begin
      roll       = $urandom_range(0, 99);
      w.set_bar  = ($urandom_range(0, 1) == 0) ?
                   bbt_pkg::BAR_SET_WIDTH'($urandom_range(0, 15)) :
                   bbt_pkg::BAR_SET_WIDTH'($urandom);
      w.set_beat = bbt_pkg::BPB_WIDTH'($urandom);
      w.set_tick = bbt_pkg::TPB_WIDTH'($urandom);
      if (roll < 60) begin
        case ($urandom_range(0, 5))
          0:       w.cmd = bbt_pkg::CMD_TICK_UP;
          1:       w.cmd = bbt_pkg::CMD_TICK_DN;
          2:       w.cmd = bbt_pkg::CMD_BEAT_UP;
          3:       w.cmd = bbt_pkg::CMD_BEAT_DN;
          4:       w.cmd = bbt_pkg::CMD_BAR_UP;
          default: w.cmd = bbt_pkg::CMD_BAR_DN;
        endcase
      end else if (roll < 75) begin
        w.cmd = bbt_pkg::CMD_SET;
      end else if (roll < 80) begin
        w.cmd = bbt_pkg::CMD_CLEAR;
      end else if (roll < 92) begin
        w.cmd = bbt_pkg::CMD_QUANTIZE;
      end else begin
        w.cmd = bbt_pkg::CMD_WIDTH'($urandom_range(int'(bbt_pkg::CMD_QUANTIZE) + 1,
                                                   2 ** bbt_pkg::CMD_WIDTH - 1));
      end
      pending_cmds.push_back(w);
    end
  endtask

  task automatic write_reg(logic [bbt_pkg::CFG_IDX_WIDTH-1:0] idx,
                           logic [bbt_pkg::CFG_DATA_WIDTH-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == bbt_pkg::REG_TICKS_PER_BEAT)
      ticks_per_beat_q = bbt_pkg::tpb_t'(value);
    else
      beats_per_bar_q = bbt_pkg::bpb_t'(value);
  endtask

  task automatic drain();
    while (pending_cmds.size() > 0 || cmds_accepted != cmds_issued ||
           expected_positions.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    bbt_pkg::tpb_t tpb_list[NUM_PHASES];
    bbt_pkg::bpb_t bpb_list[NUM_PHASES];
    cfg_write           = 1'b0;
    cfg_index           = bbt_pkg::REG_TICKS_PER_BEAT;
    cfg_data            = '0;
    command_ch.valid    = 1'b0;
    command_ch.cmd      = bbt_pkg::CMD_TICK_UP;
    command_ch.set_bar  = '0;
    command_ch.set_beat = '0;
    command_ch.set_tick = '0;
    result_ch.ready     = 1'b0;
    song_pos            = '0;
    ticks_per_beat_q    = bbt_pkg::TPB_RESET;
    beats_per_bar_q     = bbt_pkg::BPB_RESET;

    tpb_list = '{16'd0, 16'd65535, 16'd1, 16'd1, 16'd65535, bbt_pkg::TPB_WIDTH'($urandom),
                 16'd3, bbt_pkg::TPB_WIDTH'($urandom_range(1, 300))};
    bpb_list = '{8'd0, 8'd255, 8'd1, 8'd255, 8'd1, bbt_pkg::BPB_WIDTH'($urandom), 8'd7,
                 bbt_pkg::BPB_WIDTH'($urandom_range(1, 12))};

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // stepping either side of zero, truncating quantize, set extremes, unknown codes
    push_cmd(bbt_pkg::CMD_TICK_UP, 0, 0, 0);
    push_cmd(bbt_pkg::CMD_TICK_DN, 0, 0, 0);
    push_cmd(bbt_pkg::CMD_TICK_DN, 0, 0, 0);
    push_cmd(bbt_pkg::CMD_BEAT_UP, 0, 0, 0);
    push_cmd(bbt_pkg::CMD_BEAT_DN, 0, 0, 0);
    push_cmd(bbt_pkg::CMD_BAR_UP, 0, 0, 0);
    push_cmd(bbt_pkg::CMD_BAR_DN, 0, 0, 0);
    push_cmd(bbt_pkg::CMD_BAR_DN, 0, 0, 0);
    push_cmd(bbt_pkg::CMD_BEAT_DN, 0, 0, 0);
    push_cmd(bbt_pkg::CMD_QUANTIZE, 0, 0, 0);
    push_cmd(bbt_pkg::CMD_SET, 65535, 255, 65535);
    push_cmd(bbt_pkg::CMD_QUANTIZE, 0, 0, 0);
    push_cmd(bbt_pkg::CMD_SET, 0, 0, 0);
    push_cmd(bbt_pkg::CMD_SET, 1, 3, 95);
    push_cmd(bbt_pkg::CMD_CLEAR, 0, 0, 0);
    for (int c = int'(bbt_pkg::CMD_QUANTIZE) + 1; c < 2 ** bbt_pkg::CMD_WIDTH; c++)
      push_cmd(bbt_pkg::CMD_WIDTH'(c), 65535, 255, 65535);
    push_random(RANDOM_PER_PHASE);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(bbt_pkg::REG_TICKS_PER_BEAT, tpb_list[p]);
      write_reg(bbt_pkg::REG_BEATS_PER_BAR, {bbt_pkg::BPB_WIDTH'($urandom), bpb_list[p]});
      if (p == NUM_PHASES - 1)
        idling_on = 1'b0;
      push_cmd(bbt_pkg::CMD_SET, 65535, 255, 65535);
      push_cmd(bbt_pkg::CMD_TICK_DN, 0, 0, 0);
      push_cmd(bbt_pkg::CMD_QUANTIZE, 0, 0, 0);
      push_cmd(bbt_pkg::CMD_BAR_DN, 0, 0, 0);
      push_random(RANDOM_PER_PHASE);
      drain();
    end

    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

@@ files.f @@
sv/bbt_pkg.sv
sv/bbt_cmd_if.sv
sv/bbt_res_if.sv
sv/bbt_mul.sv
sv/bbt_div.sv
sv/bar_beat_tick_position_counter_core.sv
tb/tb_bar_beat_tick_position_counter_core.sv
